### rtl/pkf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the pose keyframe gate.
// Used by pkf_mul, pkf_core, pose_keyframe_gate and pkf_check; depends on nothing.
package pkf_pkg;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int TRANS_W    = 20;
  localparam int COS_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_THR   = 2'd1;

  localparam logic [TRANS_W-1:0] TRANS_THR_RESET = 20'd1000;
  localparam logic [COS_W-1:0]   COS_THR_RESET   = 16'd65299;

  // Width of each operand of the shared signed multiplier.
  localparam int MUL_W = 34;

  // Reason codes carried in the result word.
  localparam logic [2:0] REASON_FIRST   = 3'd0;
  localparam logic [2:0] REASON_MOVED   = 3'd1;
  localparam logic [2:0] REASON_STILL   = 3'd2;
  localparam logic [2:0] REASON_EMPTY   = 3'd3;
  localparam logic [2:0] REASON_NO_POSE = 3'd4;

  // One scan pose.
  typedef struct packed {
    logic signed [15:0] rot_w;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               scan_empty;
    logic               pose_valid;
  } in_word_t;

  // One keyframe decision.
  typedef struct packed {
    logic       accepted;
    logic [2:0] reason;
  } out_word_t;

  // Control from the top level into the decision core.
  typedef struct packed {
    logic               start;
    logic [TRANS_W-1:0] trans_thr;
    logic [COS_W-1:0]   cos_thr;
  } core_ctl_t;

  // Status from the decision core back to the top level.
  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_stat_t;

endpackage

### rtl/pkf_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on pkf_pkg for the operand width.
module pkf_mul (
  input  logic                                 clk,
  input  logic signed [pkf_pkg::MUL_W-1:0]     a,
  input  logic signed [pkf_pkg::MUL_W-1:0]     b,
  output logic signed [2*pkf_pkg::MUL_W-1:0]   prod
);

  // The product is registered: it lands in the cycle after the operands are presented.
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

### rtl/pkf_core.sv
`timescale 1ns / 1ps
// Keyframe decision core: sequencer, accumulators and the stored keyframe pose.
// Depends on pkf_pkg and instantiates pkf_mul.
module pkf_core (
  input  logic                 clk,
  input  logic                 rst,
  input  pkf_pkg::core_ctl_t   ctl,
  input  pkf_pkg::in_word_t    item_in,
  input  logic                 res_take,
  output pkf_pkg::core_stat_t  stat,
  output pkf_pkg::out_word_t   res
);

  localparam int MW     = pkf_pkg::MUL_W;
  localparam int STEP_W = 5;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_SQD, OP_TT, OP_C2, OP_DOT, OP_NA, OP_NB, OP_LHS, OP_M, OP_RLO, OP_RHI
  } op_t;

  // Step schedule of the shared multiplier.
  localparam logic [STEP_W-1:0] NUM_AXES = 5'd3;
  localparam logic [STEP_W-1:0] STEP_SQD = 5'd1;
  localparam logic [STEP_W-1:0] STEP_TT  = 5'd4;
  localparam logic [STEP_W-1:0] STEP_C2  = 5'd5;
  localparam logic [STEP_W-1:0] STEP_DOT = 5'd6;
  localparam logic [STEP_W-1:0] STEP_NA  = 5'd10;
  localparam logic [STEP_W-1:0] STEP_NB  = 5'd14;
  localparam logic [STEP_W-1:0] STEP_LHS = 5'd18;
  localparam logic [STEP_W-1:0] STEP_M   = 5'd19;
  localparam logic [STEP_W-1:0] STEP_RLO = 5'd21;
  localparam logic [STEP_W-1:0] STEP_RHI = 5'd22;
  localparam logic [STEP_W-1:0] STEP_END = 5'd24;

  state_t               state;
  logic [STEP_W-1:0]    cnt;
  logic                 have_kf;
  pkf_pkg::in_word_t    item;
  logic signed [15:0]   last_q [4];
  logic signed [31:0]   last_p [3];

  op_t                  op;
  op_t                  op_d;
  logic signed [MW-1:0]   mul_a;
  logic signed [MW-1:0]   mul_b;
  logic signed [2*MW-1:0] prod;

  // Accumulators and partial results.
  logic [32:0]          dreg;
  logic                 far;
  logic [41:0]          tsum;
  logic [39:0]          tt;
  logic [31:0]          c2;
  logic signed [33:0]   dot;
  logic [32:0]          na;
  logic [32:0]          nb;
  logic [64:0]          lhs;
  logic [64:0]          m;
  logic [96:0]          rhs;

  logic signed [15:0]   q_in [4];
  logic signed [31:0]   p_in [3];
  logic signed [15:0]   q_it [4];
  logic signed [31:0]   p_it [3];

  logic [1:0]           axis;
  logic signed [32:0]   diff;
  logic [32:0]          dabs;
  logic                 diff_en;
  logic [32:0]          ad;
  logic                 small_t;
  logic                 small_r;

  // Quaternion and position views of the incoming and the held item.
  always_comb begin
    q_in[0] = item_in.rot_w;
    q_in[1] = item_in.rot_x;
    q_in[2] = item_in.rot_y;
    q_in[3] = item_in.rot_z;
    p_in[0] = item_in.pos_x;
    p_in[1] = item_in.pos_y;
    p_in[2] = item_in.pos_z;
    q_it[0] = item.rot_w;
    q_it[1] = item.rot_x;
    q_it[2] = item.rot_y;
    q_it[3] = item.rot_z;
    p_it[0] = item.pos_x;
    p_it[1] = item.pos_y;
    p_it[2] = item.pos_z;
  end

  // Per-axis absolute difference against the keyframe position.
  assign axis    = cnt[1:0];
  assign diff_en = (state == ST_RUN) && (cnt < NUM_AXES);
  assign diff    = {p_it[axis][31], p_it[axis]} - {last_p[axis][31], last_p[axis]};
  assign dabs    = diff[32] ? 33'(-diff) : 33'(diff);

  // Magnitude of the quaternion dot product.
  assign ad = dot[33] ? 33'(-dot) : 33'(dot);

  // Final comparisons: squared distance and the square-root-free angle test.
  assign small_t = !far && (tsum < {2'b00, tt});
  assign small_r = {lhs, 32'd0} > rhs;

  // Operand selection for the shared multiplier.
  always_comb begin
    logic [1:0] ridx;
    op    = OP_NONE;
    mul_a = '0;
    mul_b = '0;
    ridx  = 2'(cnt - STEP_DOT);
    if (state == ST_RUN) begin
      if (cnt >= STEP_SQD && cnt < STEP_TT) begin
        op    = OP_SQD;
        mul_a = {{(MW-33){1'b0}}, dreg};
        mul_b = {{(MW-33){1'b0}}, dreg};
      end else if (cnt == STEP_TT) begin
        op    = OP_TT;
        mul_a = {{(MW-pkf_pkg::TRANS_W){1'b0}}, ctl.trans_thr};
        mul_b = {{(MW-pkf_pkg::TRANS_W){1'b0}}, ctl.trans_thr};
      end else if (cnt == STEP_C2) begin
        op    = OP_C2;
        mul_a = {{(MW-pkf_pkg::COS_W){1'b0}}, ctl.cos_thr};
        mul_b = {{(MW-pkf_pkg::COS_W){1'b0}}, ctl.cos_thr};
      end else if (cnt >= STEP_DOT && cnt < STEP_NA) begin
        op    = OP_DOT;
        mul_a = {{(MW-16){q_it[ridx][15]}}, q_it[ridx]};
        mul_b = {{(MW-16){last_q[ridx][15]}}, last_q[ridx]};
      end else if (cnt >= STEP_NA && cnt < STEP_NB) begin
        ridx  = 2'(cnt - STEP_NA);
        op    = OP_NA;
        mul_a = {{(MW-16){q_it[ridx][15]}}, q_it[ridx]};
        mul_b = {{(MW-16){q_it[ridx][15]}}, q_it[ridx]};
      end else if (cnt >= STEP_NB && cnt < STEP_LHS) begin
        ridx  = 2'(cnt - STEP_NB);
        op    = OP_NB;
        mul_a = {{(MW-16){last_q[ridx][15]}}, last_q[ridx]};
        mul_b = {{(MW-16){last_q[ridx][15]}}, last_q[ridx]};
      end else if (cnt == STEP_LHS) begin
        op    = OP_LHS;
        mul_a = {{(MW-33){1'b0}}, ad};
        mul_b = {{(MW-33){1'b0}}, ad};
      end else if (cnt == STEP_M) begin
        op    = OP_M;
        mul_a = {{(MW-33){1'b0}}, na};
        mul_b = {{(MW-33){1'b0}}, nb};
      end else if (cnt == STEP_RLO) begin
        op    = OP_RLO;
        mul_a = {{(MW-33){1'b0}}, m[32:0]};
        mul_b = {{(MW-32){1'b0}}, c2};
      end else if (cnt == STEP_RHI) begin
        op    = OP_RHI;
        mul_a = {{(MW-32){1'b0}}, m[64:33]};
        mul_b = {{(MW-32){1'b0}}, c2};
      end
    end
  end

  pkf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Datapath: clear on a new item, then fold each product into its register.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_d <= OP_NONE;
    end else begin
      op_d <= op;
    end
    if (state == ST_IDLE && ctl.start) begin
      far  <= 1'b0;
      tsum <= '0;
      dot  <= '0;
      na   <= '0;
      nb   <= '0;
    end else begin
      if (diff_en) begin
        dreg <= dabs;
        if (dabs > {13'd0, ctl.trans_thr}) begin
          far <= 1'b1;
        end
      end
      case (op_d)
        OP_SQD:  tsum <= tsum + prod[41:0];
        OP_TT:   tt   <= prod[39:0];
        OP_C2:   c2   <= prod[31:0];
        OP_DOT:  dot  <= dot + $signed(prod[33:0]);
        OP_NA:   na   <= na + prod[32:0];
        OP_NB:   nb   <= nb + prod[32:0];
        OP_LHS:  lhs  <= prod[64:0];
        OP_M:    m    <= prod[64:0];
        OP_RLO:  rhs  <= {32'd0, prod[64:0]};
        OP_RHI:  rhs  <= rhs + {prod[63:0], 33'd0};
        default: ;
      endcase
    end
  end

  // Sequencer, keyframe state and the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      have_kf <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ctl.start) begin
            item <= item_in;
            cnt  <= '0;
            if (item_in.scan_empty) begin
              res   <= '{accepted: 1'b0, reason: pkf_pkg::REASON_EMPTY};
              state <= ST_DONE;
            end else if (!item_in.pose_valid) begin
              res   <= '{accepted: 1'b0, reason: pkf_pkg::REASON_NO_POSE};
              state <= ST_DONE;
            end else if (!have_kf) begin
              res     <= '{accepted: 1'b1, reason: pkf_pkg::REASON_FIRST};
              have_kf <= 1'b1;
              for (int i = 0; i < 4; i++) last_q[i] <= q_in[i];
              for (int i = 0; i < 3; i++) last_p[i] <= p_in[i];
              state <= ST_DONE;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (cnt == STEP_END) begin
            if (small_t && small_r) begin
              res <= '{accepted: 1'b0, reason: pkf_pkg::REASON_STILL};
            end else begin
              res <= '{accepted: 1'b1, reason: pkf_pkg::REASON_MOVED};
              for (int i = 0; i < 4; i++) last_q[i] <= q_it[i];
              for (int i = 0; i < 3; i++) last_p[i] <= p_it[i];
            end
            state <= ST_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign stat.idle      = (state == ST_IDLE);
  assign stat.res_valid = (state == ST_DONE);

endmodule

### rtl/pose_keyframe_gate.sv
`timescale 1ns / 1ps
// Channel  Handshake              Word
// in       in_valid / in_ready    in_data   (pkf_pkg::in_word_t, one scan pose)
// out      out_valid / out_ready  out_data  (pkf_pkg::out_word_t, accept flag and reason)
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (threshold registers)
//
// A pose that needs the full motion test runs through 25 sequencer steps on the one
// shared 34x34 multiplier; the core then hands the word to the output register and
// returns to idle, and only then takes the next pose.
// An empty scan, an invalid pose or the first keyframe skip the sequencer steps.
// Reset is synchronous; it clears the keyframe flag and loads the default thresholds.
// A stalled output word holds in the output register; the core keeps its finished
// word meanwhile and takes no new pose until that word has moved on.
//
// Top level of the pose keyframe gate; depends on pkf_pkg, pkf_core and pkf_mul.
module pose_keyframe_gate (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pkf_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pkf_pkg::out_word_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pkf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pkf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [pkf_pkg::TRANS_W-1:0] trans_thr;
  logic [pkf_pkg::COS_W-1:0]   cos_thr;
  pkf_pkg::core_ctl_t          ctl;
  pkf_pkg::core_stat_t         stat;
  pkf_pkg::out_word_t          res;
  logic                        res_take;

  // Threshold registers; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trans_thr <= pkf_pkg::TRANS_THR_RESET;
      cos_thr   <= pkf_pkg::COS_THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pkf_pkg::CFG_TRANS_THR: trans_thr <= cfg_data[pkf_pkg::TRANS_W-1:0];
        pkf_pkg::CFG_COS_THR:   cos_thr   <= cfg_data[pkf_pkg::COS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input side: the core takes a pose whenever it is idle.
  assign in_ready      = stat.idle;
  assign ctl.start     = in_valid && stat.idle;
  assign ctl.trans_thr = trans_thr;
  assign ctl.cos_thr   = cos_thr;

  pkf_core u_core (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .item_in  (in_data),
    .res_take (res_take),
    .stat     (stat),
    .res      (res)
  );

  // Output register between the core and the result channel.
  assign res_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= stat.res_valid;
    end
    if (res_take && stat.res_valid) begin
      out_data <= res;
    end
  end

endmodule

### rtl/pkf_check.sv
`timescale 1ns / 1ps
// Port-level checks for the pose keyframe gate, bound to the top level.
// Depends on pkf_pkg and pose_keyframe_gate.
module pkf_assert (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input pkf_pkg::out_word_t                  out_data,
  input logic                                cfg_valid,
  input logic                                cfg_ready
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // The accept flag agrees with the reason code, and the code is a known one.
  a_reason_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.accepted == (out_data.reason == pkf_pkg::REASON_FIRST ||
                                         out_data.reason == pkf_pkg::REASON_MOVED)) &&
                  (out_data.reason == pkf_pkg::REASON_FIRST ||
                   out_data.reason == pkf_pkg::REASON_MOVED ||
                   out_data.reason == pkf_pkg::REASON_STILL ||
                   out_data.reason == pkf_pkg::REASON_EMPTY ||
                   out_data.reason == pkf_pkg::REASON_NO_POSE))
    else $error("accept flag and reason disagree");

  // A pose is worked on alone: no second pose is taken in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second pose taken while the first is in flight");

  // The threshold port never stalls.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind pose_keyframe_gate pkf_assert u_pkf_assert (.*);
